/* rtl/first_fit_block_allocator_macros.svh */
// Assertion helpers for the allocator datapath RTL
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define FFBA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, constants and controller command codes for the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

    localparam int ARENA_BYTES  = 65536;
    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 40;
    localparam int BLK_AW       = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = BLK_AW + 1;
    localparam int SZ_W         = 16;
    localparam int TOP_W        = 17;
    localparam int LIM_MAX      = (ARENA_BYTES < 65536) ? ARENA_BYTES : 65536;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic [SZ_W-1:0] start;
        logic [SZ_W-1:0] size;
        logic            fr;
    } blk_t;

    localparam int BLK_W = $bits(blk_t);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD,
        OP_ADV,
        OP_HIT,
        OP_TAKE,
        OP_SPLIT_INIT,
        OP_RD_DN,
        OP_MV_UP,
        OP_SPLIT_WR0,
        OP_SPLIT_WR1,
        OP_APPEND,
        OP_RD_NXT,
        OP_LAT_NXT,
        OP_CLR_NXT,
        OP_MERGE
    } op_t;

    typedef enum logic [1:0] {
        XOP_NONE,
        XOP_RD_FWD,
        XOP_MV_DN,
        XOP_RM_END
    } xop_t;

    typedef struct packed {
        op_t        op;
        xop_t       xop;
        logic       finish;
        logic [1:0] fin_status;
    } dp_cmd_t;

    typedef struct packed {
        logic req_free;
        logic req_zero;
        logic addr_null;
        logic scan_end;
        logic hit;
        logic split_ok;
        logic room;
        logic cur_free;
        logic has_next;
        logic ins_done;
        logic merge_none;
        logic rm_done;
    } dp_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_A_HIT,
        S_A_SH_RD,
        S_A_SH_WR,
        S_A_SPLIT,
        S_A_APP,
        S_F_HIT,
        S_F_NXT,
        S_F_MERGE,
        S_F_RM_RD,
        S_F_RM_WR
    } st_t;

endpackage

`default_nettype wire

/* rtl/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over an address-ordered block table, with split and
// coalesce, plus an APB register for the heap limit.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy low; its one result word
// appears on payload_addr/status for a single cycle with done high and must be
// captured then, as the receiver cannot stall it. A request scans the table one
// entry at a time (one RAM read, then one compare); when a split or merge shifts
// the table through the single RAM write port, each entry moved takes a read
// and then a write, and setup and result steps come before and after. A
// zero-size or null request passes only through the start, dispatch and result
// steps. The longest requests are a full scan of a full table ending in an
// append check, or a free near the front that merges both ways and shifts the
// rest of the table down.
// No clearing pass is needed after reset; entries above the block count are
// never read.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic            req_type,
    input  wire logic [SZ_W-1:0] alloc_size,
    input  wire logic [SZ_W-1:0] block_addr,
    output logic                 done,
    output logic [SZ_W-1:0]      payload_addr,
    output logic [1:0]           status,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [2:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [TOP_W-1:0] heap_limit_reg;
    logic [TOP_W-1:0] heap_limit_next;
    logic             cfg_wr;
    dp_cmd_t          cmd;
    dp_stat_t         stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);

    always_comb
    begin
        heap_limit_next = heap_limit_reg;
        if (cfg_wr)
        begin
            heap_limit_next = pwdata[TOP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_limit_reg <= TOP_W'(65536);
        end
        else
        begin
            heap_limit_reg <= heap_limit_next;
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? {{(32-TOP_W){1'b0}}, heap_limit_reg} : 32'd0;

    ffba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    ffba_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_type      (req_type),
        .in_size      (alloc_size),
        .in_addr      (block_addr),
        .limit        (heap_limit_reg),
        .stat         (stat),
        .done         (done),
        .payload_addr (payload_addr),
        .status       (status)
    );

endmodule

`default_nettype wire

/* rtl/ffba_ram.sv */
// ----------------------------------------------------------------------------
// ffba_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/ffba_ctrl.sv */
// ----------------------------------------------------------------------------
// ffba_ctrl
// Request sequencer: scan, split, append, merge and table shifting steps.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ctrl
    import ffba_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd,
    output logic          busy
);

    st_t state_reg;
    st_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if ((!stat.req_free && stat.req_zero) || (stat.req_free && stat.addr_null))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (!stat.scan_end)
                begin
                    state_next = S_SCAN_CHK;
                end
                else if (stat.req_free)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_A_APP;
                end
            end
            S_SCAN_CHK:
            begin
                if (!stat.hit)
                begin
                    state_next = S_SCAN_RD;
                end
                else if (stat.req_free)
                begin
                    state_next = S_F_HIT;
                end
                else
                begin
                    state_next = S_A_HIT;
                end
            end
            S_A_HIT:   state_next = stat.split_ok ? S_A_SH_RD : S_IDLE;
            S_A_SH_RD: state_next = stat.ins_done ? S_A_SPLIT : S_A_SH_WR;
            S_A_SH_WR: state_next = S_A_SH_RD;
            S_A_SPLIT: state_next = S_IDLE;
            S_A_APP:   state_next = S_IDLE;
            S_F_HIT:
            begin
                if (stat.cur_free)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.has_next)
                begin
                    state_next = S_F_NXT;
                end
                else
                begin
                    state_next = S_F_MERGE;
                end
            end
            S_F_NXT:   state_next = S_F_MERGE;
            S_F_MERGE: state_next = stat.merge_none ? S_IDLE : S_F_RM_RD;
            S_F_RM_RD: state_next = stat.rm_done ? S_IDLE : S_F_RM_WR;
            S_F_RM_WR: state_next = S_F_RM_RD;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.op         = OP_NONE;
        cmd.xop        = XOP_NONE;
        cmd.fin_status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            S_DISP:
            begin
                if (!stat.req_free && stat.req_zero)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_ZERO;
                end
                else if (stat.req_free && stat.addr_null)
                begin
                    cmd.finish = 1'b1;
                end
            end
            S_SCAN_RD:
            begin
                if (!stat.scan_end)
                begin
                    cmd.op = OP_RD;
                end
                else if (stat.req_free)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_BADFREE;
                end
            end
            S_SCAN_CHK: cmd.op = stat.hit ? OP_HIT : OP_ADV;
            S_A_HIT:
            begin
                if (stat.split_ok)
                begin
                    cmd.op = OP_SPLIT_INIT;
                end
                else
                begin
                    cmd.op     = OP_TAKE;
                    cmd.finish = 1'b1;
                end
            end
            S_A_SH_RD: cmd.op = stat.ins_done ? OP_SPLIT_WR0 : OP_RD_DN;
            S_A_SH_WR: cmd.op = OP_MV_UP;
            S_A_SPLIT:
            begin
                cmd.op     = OP_SPLIT_WR1;
                cmd.finish = 1'b1;
            end
            S_A_APP:
            begin
                cmd.finish = 1'b1;
                if (stat.room)
                begin
                    cmd.op = OP_APPEND;
                end
                else
                begin
                    cmd.fin_status = ST_NOSPACE;
                end
            end
            S_F_HIT:
            begin
                if (stat.cur_free)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_BADFREE;
                end
                else
                begin
                    cmd.op = stat.has_next ? OP_RD_NXT : OP_CLR_NXT;
                end
            end
            S_F_NXT:   cmd.op = OP_LAT_NXT;
            S_F_MERGE:
            begin
                cmd.op     = OP_MERGE;
                cmd.finish = stat.merge_none;
            end
            S_F_RM_RD:
            begin
                if (stat.rm_done)
                begin
                    cmd.xop    = XOP_RM_END;
                    cmd.finish = 1'b1;
                end
                else
                begin
                    cmd.xop = XOP_RD_FWD;
                end
            end
            S_F_RM_WR: cmd.xop = XOP_MV_DN;
            default:   cmd.op  = OP_NONE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

/* rtl/ffba_dp.sv */
// ----------------------------------------------------------------------------
// ffba_dp
// Allocator datapath: block table RAM, request registers, counters, results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_fit_block_allocator_macros.svh"

module ffba_dp
    import ffba_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dp_cmd_t          cmd,
    input  wire logic             in_type,
    input  wire logic [SZ_W-1:0]  in_size,
    input  wire logic [SZ_W-1:0]  in_addr,
    input  wire logic [TOP_W-1:0] limit,
    output dp_stat_t              stat,
    output logic                  done,
    output logic [SZ_W-1:0]       payload_addr,
    output logic [1:0]            status
);

    localparam logic [TOP_W-1:0] HDR17 = TOP_W'(HEADER_BYTES);
    localparam logic [TOP_W-1:0] LIM17 = TOP_W'(LIM_MAX);

    logic              req_type_reg;
    logic [SZ_W-1:0]   size_reg;
    logic [SZ_W-1:0]   addr_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  idx_next;
    logic [BLK_AW-1:0] base_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [TOP_W-1:0]  heap_top_reg;
    logic [TOP_W-1:0]  heap_top_next;
    blk_t              cur_reg;
    blk_t              prev_reg;
    blk_t              nxt_reg;
    logic [1:0]        d_reg;
    logic              done_reg;
    logic [1:0]        status_reg;
    logic [SZ_W-1:0]   payload_addr_reg;

    logic              we;
    logic [BLK_AW-1:0] waddr;
    blk_t              wdata;
    logic [BLK_AW-1:0] raddr;
    logic [BLK_W-1:0]  rdata_raw;
    blk_t              rdata;

    logic [CNT_W-1:0]  base_ext;
    logic [CNT_W-1:0]  base_p1;
    logic [TOP_W-1:0]  req_hdr;
    logic [TOP_W-1:0]  lim_now;
    logic [TOP_W:0]    top_end;
    logic              pf;
    logic              nf;
    logic [TOP_W-1:0]  merged_size;
    logic [TOP_W-1:0]  cur_end;
    logic [SZ_W-1:0]   rest;
    logic [TOP_W-1:0]  res_addr;

    ffba_ram #(
        .WIDTH (BLK_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign rdata    = blk_t'(rdata_raw);
    assign base_ext = {1'b0, base_reg};
    assign base_p1  = base_ext + CNT_W'(1);
    assign req_hdr  = {1'b0, size_reg} + HDR17;
    assign lim_now  = (limit > LIM17) ? LIM17 : limit;
    assign top_end  = {1'b0, heap_top_reg} + {1'b0, req_hdr};
    assign pf       = (base_reg != '0) && prev_reg.fr;
    assign nf       = nxt_reg.fr;
    assign cur_end  = {1'b0, cur_reg.start} + req_hdr;
    assign rest     = SZ_W'({1'b0, cur_reg.size} - req_hdr);

    always_comb
    begin
        merged_size = {1'b0, cur_reg.size};
        if (pf)
        begin
            merged_size = merged_size + {1'b0, prev_reg.size} + HDR17;
        end
        if (nf)
        begin
            merged_size = merged_size + {1'b0, nxt_reg.size} + HDR17;
        end
    end

    // status towards the sequencer
    always_comb
    begin
        stat.req_free   = req_type_reg;
        stat.req_zero   = (size_reg == '0);
        stat.addr_null  = (addr_reg == '0);
        stat.scan_end   = (idx_reg >= count_reg);
        if (req_type_reg == REQ_FREE)
        begin
            stat.hit = (({1'b0, rdata.start} + HDR17) == {1'b0, addr_reg});
        end
        else
        begin
            stat.hit = rdata.fr && (rdata.size >= size_reg);
        end
        stat.split_ok   = ({1'b0, cur_reg.size} > req_hdr) &&
                          (count_reg < CNT_W'(MAX_BLOCKS));
        stat.room       = (count_reg < CNT_W'(MAX_BLOCKS)) &&
                          (top_end <= {1'b0, lim_now});
        stat.cur_free   = cur_reg.fr;
        stat.has_next   = (base_p1 < count_reg);
        stat.ins_done   = (idx_reg == base_p1);
        stat.merge_none = !pf && !nf;
        stat.rm_done    = ({1'b0, idx_reg} + {{(CNT_W-1){1'b0}}, d_reg}) >= {1'b0, count_reg};
    end

    // table port selection
    always_comb
    begin
        we    = 1'b0;
        waddr = base_reg;
        wdata = cur_reg;
        raddr = idx_reg[BLK_AW-1:0];
        unique case (cmd.op)
            OP_RD_DN:  raddr = BLK_AW'(idx_reg - CNT_W'(1));
            OP_RD_NXT: raddr = base_p1[BLK_AW-1:0];
            OP_TAKE:
            begin
                we       = 1'b1;
                wdata.fr = 1'b0;
            end
            OP_MV_UP:
            begin
                we    = 1'b1;
                waddr = idx_reg[BLK_AW-1:0];
                wdata = rdata;
            end
            OP_SPLIT_WR0:
            begin
                we          = 1'b1;
                waddr       = base_p1[BLK_AW-1:0];
                wdata.start = cur_end[SZ_W-1:0];
                wdata.size  = rest;
                wdata.fr    = 1'b1;
            end
            OP_SPLIT_WR1:
            begin
                we         = 1'b1;
                wdata.size = size_reg;
                wdata.fr   = 1'b0;
            end
            OP_APPEND:
            begin
                we          = 1'b1;
                waddr       = count_reg[BLK_AW-1:0];
                wdata.start = heap_top_reg[SZ_W-1:0];
                wdata.size  = size_reg;
                wdata.fr    = 1'b0;
            end
            OP_MERGE:
            begin
                we          = 1'b1;
                waddr       = pf ? BLK_AW'(base_reg - BLK_AW'(1)) : base_reg;
                wdata.start = pf ? prev_reg.start : cur_reg.start;
                wdata.size  = merged_size[SZ_W-1:0];
                wdata.fr    = 1'b1;
            end
            default:   we = 1'b0;
        endcase
        unique case (cmd.xop)
            XOP_RD_FWD: raddr = BLK_AW'(idx_reg + {{(CNT_W-2){1'b0}}, d_reg});
            XOP_MV_DN:
            begin
                we    = 1'b1;
                waddr = idx_reg[BLK_AW-1:0];
                wdata = rdata;
            end
            default:    raddr = raddr;
        endcase
    end

    always_comb
    begin
        res_addr = '0;
        unique case (cmd.op)
            OP_TAKE, OP_SPLIT_WR1: res_addr = {1'b0, cur_reg.start} + HDR17;
            OP_APPEND:             res_addr = heap_top_reg + HDR17;
            default:               res_addr = '0;
        endcase
    end

    always_comb
    begin
        idx_next      = idx_reg;
        count_next    = count_reg;
        heap_top_next = heap_top_reg;
        unique case (cmd.op)
            OP_LOAD:       idx_next = '0;
            OP_ADV:        idx_next = idx_reg + CNT_W'(1);
            OP_SPLIT_INIT: idx_next = count_reg;
            OP_MV_UP:      idx_next = idx_reg - CNT_W'(1);
            OP_SPLIT_WR1:  count_next = count_reg + CNT_W'(1);
            OP_APPEND:
            begin
                count_next    = count_reg + CNT_W'(1);
                heap_top_next = top_end[TOP_W-1:0];
            end
            OP_MERGE:      idx_next = pf ? base_ext : base_p1;
            default:       idx_next = idx_reg;
        endcase
        unique case (cmd.xop)
            XOP_MV_DN:  idx_next = idx_reg + CNT_W'(1);
            XOP_RM_END: count_next = count_reg - {{(CNT_W-2){1'b0}}, d_reg};
            default:    idx_next = idx_next;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            heap_top_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            heap_top_reg <= heap_top_next;
            done_reg     <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.op == OP_LOAD)
        begin
            req_type_reg <= in_type;
            size_reg     <= in_size;
            addr_reg     <= in_addr;
        end
        if (cmd.op == OP_ADV)
        begin
            prev_reg <= rdata;
        end
        if (cmd.op == OP_HIT)
        begin
            cur_reg  <= rdata;
            base_reg <= idx_reg[BLK_AW-1:0];
        end
        if (cmd.op == OP_LAT_NXT)
        begin
            nxt_reg <= rdata;
        end
        if (cmd.op == OP_CLR_NXT)
        begin
            nxt_reg.fr <= 1'b0;
        end
        if (cmd.op == OP_MERGE)
        begin
            d_reg <= {1'b0, pf} + {1'b0, nf};
        end
        if (cmd.finish)
        begin
            status_reg       <= cmd.fin_status;
            payload_addr_reg <= res_addr[SZ_W-1:0];
        end
    end

    assign done         = done_reg;
    assign payload_addr = payload_addr_reg;
    assign status       = status_reg;

    `FFBA_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_BLOCKS), "block count overflow")
    `FFBA_ASSERT_NEXT(a_top_grows, 1'b1, heap_top_reg >= $past(heap_top_reg), "heap top shrank")
    `FFBA_ASSERT_IMPL(a_free_no_addr, done_reg && (req_type_reg == REQ_FREE), payload_addr_reg == '0, "free returned address")

endmodule

`default_nettype wire
